// ===== rtl/encoder_detent_accelerator_macros.svh =====
// Assertion macros used by the encoder detent accelerator top level.
`ifndef ENCODER_DETENT_ACCELERATOR_MACROS_SVH
`define ENCODER_DETENT_ACCELERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define EDA_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("encoder detent accelerator: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define EDA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("encoder detent accelerator: next-cycle check failed");
`else
`define EDA_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define EDA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/eda_pkg.sv =====
// Types, register codes and reset values for the encoder detent accelerator.
package eda_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [1:0] CH_DIRECT   = 2'd1;
    localparam logic [1:0] CH_DEC_ONLY = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP_WINDOW  = 3'd0,
        REG_FAST_WINDOW  = 3'd1,
        REG_PLAIN_DETENT = 3'd2,
        REG_FAST_DETENT  = 3'd3,
        REG_RUN_FACTOR   = 3'd4,
        REG_TOP_FACTOR   = 3'd5,
        REG_STROKE_REV   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         channel;
        logic signed [7:0]  steps;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic signed [11:0] adjustment;
        logic               top_active;
    } out_item_t;

    typedef struct packed {
        logic [15:0] step_window_ms;
        logic [15:0] fast_window_ms;
        logic [7:0]  plain_detents;
        logic [7:0]  fast_detents;
        logic [3:0]  run_factor;
        logic [3:0]  top_factor;
        logic        stroke_reversed;
    } cfg_t;

    typedef struct packed {
        logic [8:0]  run_count;
        logic [7:0]  fast_count;
        logic [31:0] last_time;
        logic        last_negative;
        logic        has_previous;
    } chan_state_t;

    localparam cfg_t CFG_RESET = '{
        step_window_ms:  16'd150,
        fast_window_ms:  16'd60,
        plain_detents:   8'd2,
        fast_detents:    8'd6,
        run_factor:      4'd2,
        top_factor:      4'd4,
        stroke_reversed: 1'b0
    };

endpackage

// ===== rtl/eda_accel.sv =====
// Per-item acceleration datapath: result and next channel state from one item.
module eda_accel (
    input  eda_pkg::in_item_t    item,
    input  eda_pkg::cfg_t        cfg,
    input  eda_pkg::chan_state_t cur,
    input  logic                 has_state,
    output eda_pkg::out_item_t   result,
    output logic                 upd,
    output eda_pkg::chan_state_t nxt
);
    import eda_pkg::*;

    logic               neg;
    logic [7:0]         mag;
    logic               same;
    logic [31:0]        gap;
    logic               cont_run;
    logic               cont_fast;
    logic               allowed;
    logic [8:0]         prev;
    logic [8:0]         seq_end;
    logic [8:0]         fast_seq;
    logic [8:0]         plain_ext;
    logic [8:0]         plain_p1;
    logic [8:0]         fast_ext;
    logic [8:0]         start;
    logic [8:0]         cont_wide;
    logic [7:0]         cont;
    logic               top;
    logic [3:0]         factor;
    logic [11:0]        prod;
    logic [11:0]        amag;
    logic [11:0]        accel_adj;
    logic signed [11:0] steps_ext;
    logic               is_zero;

    assign neg       = item.steps[7];
    assign mag       = neg ? 8'(-item.steps) : 8'(item.steps);
    assign steps_ext = 12'(item.steps);
    assign is_zero   = (item.steps == 8'sd0);

    assign same      = cur.has_previous && (cur.last_negative == neg);
    assign gap       = item.now_ms - cur.last_time;
    assign cont_run  = same && (gap <= 32'(cfg.step_window_ms));
    assign cont_fast = same && (gap <= 32'(cfg.fast_window_ms));
    assign allowed   = (item.channel != CH_DEC_ONLY) || neg;

    assign plain_ext = 9'(cfg.plain_detents);
    assign plain_p1  = plain_ext + 9'd1;
    assign fast_ext  = 9'(cfg.fast_detents);
    assign prev      = cont_run ? cur.run_count : 9'd0;
    assign seq_end   = prev + 9'(mag);
    assign fast_seq  = (cont_fast ? 9'(cur.fast_count) : 9'd0) + 9'(mag);

    // Detents already counted in the run, or the plain allowance, whichever is larger.
    assign start     = (prev > plain_ext) ? prev : plain_ext;
    assign cont_wide = (allowed && seq_end > plain_ext) ? (seq_end - start) : 9'd0;
    assign cont      = cont_wide[7:0];
    assign top       = allowed && (fast_seq >= fast_ext);

    // Plain detents pass once, continuous ones are scaled by the active factor.
    assign factor    = top ? cfg.top_factor : cfg.run_factor;
    assign prod      = 12'(cont) * 12'(factor);
    assign amag      = 12'(mag - cont) + prod;
    assign accel_adj = neg ? 12'(~amag + 12'd1) : amag;

    assign upd = (item.kind == KIND_STEP) && !is_zero && (item.channel != CH_DIRECT) && has_state;

    always_comb begin
        nxt.run_count     = (seq_end > plain_p1) ? plain_p1 : seq_end;
        nxt.fast_count    = (fast_seq > fast_ext) ? cfg.fast_detents : fast_seq[7:0];
        nxt.last_time     = item.now_ms;
        nxt.last_negative = neg;
        nxt.has_previous  = 1'b1;
    end

    always_comb begin
        result.out_channel = item.channel;
        result.adjustment  = 12'sd0;
        result.top_active  = 1'b0;
        if (item.kind == KIND_CLEAR || is_zero) begin
            result.adjustment = 12'sd0;
        end else if (item.channel == CH_DIRECT) begin
            result.adjustment = cfg.stroke_reversed ? steps_ext : -steps_ext;
        end else if (!has_state) begin
            result.adjustment = steps_ext;
        end else begin
            result.adjustment = accel_adj;
            result.top_active = top;
        end
    end

endmodule

// ===== rtl/encoder_detent_accelerator.sv =====
// Top level of the rotary encoder detent accelerator.
// Usage:
//   Items enter on the s_ channel (valid/ready) as an in_item_t: a step with
//   channel, signed detents and a millisecond timestamp, or a clear of all
//   channel history. Every item yields exactly one out_item_t on the m_
//   channel, in order.
//   Configuration registers are written through cfg_valid/cfg_index/cfg_data;
//   cfg_ready is always high, and writes are meant for when the block is idle.
//   An accepted item is held in the input register; when the output can advance,
//   its result loads into the result register and is offered on the m_ channel.
//   Throughput: one item per cycle while the receiver does not stall; the
//   channel state is updated as the result is registered.
//   Reset (aresetn low at a clock edge) empties both stages, clears all
//   channel history and loads the default register values.
//   When the receiver stalls, the result register holds its transfer and the
//   input register still takes one more item; after that s_ready drops until
//   m_ready returns.
`include "encoder_detent_accelerator_macros.svh"
module encoder_detent_accelerator #(
    parameter int CHANNELS = eda_pkg::CHANNELS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  eda_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output eda_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [eda_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eda_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import eda_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    in_item_t    in_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;
    chan_state_t state_reg  [CHANNELS];
    chan_state_t state_next [CHANNELS];

    chan_state_t cur_state;
    chan_state_t upd_state;
    out_item_t   result;
    logic        upd;
    logic        has_state;
    logic        advance;
    logic        fire;
    logic        any_prev;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = advance && in_valid_reg;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;
    assign has_state = int'(in_reg.channel) < CHANNELS;

    always_comb begin
        cur_state = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (int'(in_reg.channel) == i) begin
                cur_state = state_reg[i];
            end
        end
    end

    always_comb begin
        any_prev = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            any_prev = any_prev | state_reg[i].has_previous;
        end
    end

    eda_accel u_accel (
        .item      (in_reg),
        .cfg       (cfg_reg),
        .cur       (cur_state),
        .has_state (has_state),
        .result    (result),
        .upd       (upd),
        .nxt       (upd_state)
    );

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            state_next[i] = state_reg[i];
            if (fire) begin
                if (in_reg.kind == KIND_CLEAR) begin
                    state_next[i] = '0;
                end else if (upd && int'(in_reg.channel) == i) begin
                    state_next[i] = upd_state;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= CFG_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                state_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            for (int i = 0; i < CHANNELS; i++) begin
                state_reg[i] <= state_next[i];
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_STEP_WINDOW:  cfg_reg.step_window_ms  <= cfg_data;
                    REG_FAST_WINDOW:  cfg_reg.fast_window_ms  <= cfg_data;
                    REG_PLAIN_DETENT: cfg_reg.plain_detents   <= cfg_data[7:0];
                    REG_FAST_DETENT:  cfg_reg.fast_detents    <= cfg_data[7:0];
                    REG_RUN_FACTOR:   cfg_reg.run_factor      <= cfg_data[3:0];
                    REG_TOP_FACTOR:   cfg_reg.top_factor      <= cfg_data[3:0];
                    REG_STROKE_REV:   cfg_reg.stroke_reversed <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload stages carry no reset; their valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    `EDA_ASSERT_IMPLIES(a_full_stall_blocks_input, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `EDA_ASSERT_NEXT(a_fire_loads_result, aclk, aresetn, fire, m_valid)
    `EDA_ASSERT_NEXT(a_clear_empties_history, aclk, aresetn, fire && in_reg.kind == KIND_CLEAR, !any_prev)

endmodule
